### design/tcw_pkg.sv
// Package for the text console writer: field widths, operation and register
// codes, the sequencer state type and the configuration struct.
// Depends on nothing; every other file but tcw_cell_ram.sv imports it.
package tcw_pkg;

  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 25;

  localparam int OP_W       = 2;
  localparam int CHAR_W     = 8;
  localparam int COLOR_W    = 8;
  localparam int IDX_W      = 11;
  localparam int POS_W      = 11;
  localparam int CELL_W     = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_TEXT_COLOR    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CURSOR_FOLLOW = 1'd1;

  localparam logic [CELL_W-1:0]  BLANK_CELL   = 16'h0F20;
  localparam logic [CHAR_W-1:0]  NEWLINE_CHAR = 8'h0A;
  localparam logic [COLOR_W-1:0] RESET_COLOR  = 8'h0F;
  localparam logic               RESET_FOLLOW = 1'b1;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_PUT,
    ST_READ,
    ST_CLEAR,
    ST_SCROLL,
    ST_FLUSH,
    ST_ZERO,
    ST_DONE
  } tcw_state_t;

  typedef struct packed {
    logic [COLOR_W-1:0] text_color;
    logic               cursor_follow;
  } tcw_cfg_t;

endpackage

### design/tcw_if.sv
// Valid/ready channel interfaces of the text console writer: the command
// channel and the result channel. Depends on tcw_pkg.
interface tcw_in_if
  import tcw_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [CHAR_W-1:0] character;
  logic [IDX_W-1:0]  cell_index;

  modport source (output valid, output operation, output character, output cell_index,
                  input ready);
  modport sink   (input valid, input operation, input character, input cell_index,
                  output ready);
endinterface

interface tcw_out_if
  import tcw_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [POS_W-1:0]  cursor_position;
  logic              cursor_written;
  logic [CELL_W-1:0] cell_data;

  modport source (output valid, output cursor_position, output cursor_written,
                  output cell_data, input ready);
  modport sink   (input valid, input cursor_position, input cursor_written,
                  input cell_data, output ready);
endinterface

### design/tcw_cell_ram.sv
// Screen cell memory: one write port and one registered read port.
// Depends on nothing beyond its parameters.
module tcw_cell_ram #(
  parameter int DEPTH  = 2000,
  parameter int DATA_W = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] cells_r [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      cells_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= cells_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### design/tcw_ctrl.sv
// Sequencer of the text console writer: cursor, shared sweep counter for
// clear, scroll and bottom-row zeroing, and the result register.
// Depends on tcw_pkg and the channel interfaces in tcw_if.sv.
module tcw_ctrl
  import tcw_pkg::*;
#(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS,
  parameter int ADDR_W  = $clog2(COLUMNS * ROWS)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  tcw_cfg_t          cfg,
  tcw_in_if.sink            in_ch,
  tcw_out_if.source         out_ch,
  output logic              mem_wr_en,
  output logic [ADDR_W-1:0] mem_wr_addr,
  output logic [CELL_W-1:0] mem_wr_data,
  output logic              mem_rd_en,
  output logic [ADDR_W-1:0] mem_rd_addr,
  input  logic [CELL_W-1:0] mem_rd_data
);

  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int COL_W      = $clog2(COLUMNS);
  localparam int ROW_W      = $clog2(ROWS);
  localparam int CNT_W      = $clog2(CELL_COUNT + 1);
  localparam int CMP_W      = (CNT_W > IDX_W) ? CNT_W : IDX_W;

  localparam logic [COL_W-1:0]  LAST_COL     = COL_W'(COLUMNS - 1);
  localparam logic [ROW_W-1:0]  LAST_ROW     = ROW_W'(ROWS - 1);
  localparam logic [ADDR_W-1:0] LAST_CELL    = ADDR_W'(CELL_COUNT - 1);
  localparam logic [ADDR_W-1:0] ROW_STEP     = ADDR_W'(COLUMNS);
  localparam logic [ADDR_W-1:0] BOTTOM_START = ADDR_W'((ROWS - 1) * COLUMNS);
  localparam logic [CMP_W-1:0]  CELL_LIMIT   = CMP_W'(CELL_COUNT);

  tcw_state_t state_r, state_nxt;

  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [ADDR_W-1:0] cnt_r, cnt_nxt;
  logic [ADDR_W-1:0] wdst_r, wdst_nxt;
  logic              pend_r, pend_nxt;
  logic [CHAR_W-1:0] ch_r, ch_nxt;

  logic [POS_W-1:0]  res_pos_r, res_pos_nxt;
  logic              res_wr_r, res_wr_nxt;
  logic [CELL_W-1:0] res_cell_r, res_cell_nxt;

  logic              out_valid_r;
  logic [POS_W-1:0]  out_pos_r;
  logic              out_wr_r;
  logic [CELL_W-1:0] out_cell_r;

  logic              load_out;
  logic [POS_W-1:0]  ld_pos;
  logic              ld_wr;
  logic [CELL_W-1:0] ld_cell;

  logic              out_free;
  logic              accept;
  logic              is_newline;
  logic              wrap;
  logic [CMP_W-1:0]  idx_ext;
  logic [POS_W-1:0]  put_pos;

  assign out_free   = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE);
  assign accept     = in_ch.valid && in_ch.ready;
  assign is_newline = (ch_r == NEWLINE_CHAR);
  assign wrap       = is_newline || (col_r == LAST_COL);
  assign idx_ext    = CMP_W'(in_ch.cell_index);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
      col_r   <= '0;
      row_r   <= '0;
      addr_r  <= '0;
      cnt_r   <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      addr_r  <= addr_nxt;
      cnt_r   <= cnt_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wdst_r     <= wdst_nxt;
    ch_r       <= ch_nxt;
    res_pos_r  <= res_pos_nxt;
    res_wr_r   <= res_wr_nxt;
    res_cell_r <= res_cell_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    col_nxt      = col_r;
    row_nxt      = row_r;
    addr_nxt     = addr_r;
    cnt_nxt      = cnt_r;
    wdst_nxt     = wdst_r;
    pend_nxt     = pend_r;
    ch_nxt       = ch_r;
    res_pos_nxt  = res_pos_r;
    res_wr_nxt   = res_wr_r;
    res_cell_nxt = res_cell_r;
    load_out     = 1'b0;
    ld_pos       = res_pos_r;
    ld_wr        = res_wr_r;
    ld_cell      = res_cell_r;
    mem_wr_en    = 1'b0;
    mem_wr_addr  = cnt_r;
    mem_wr_data  = BLANK_CELL;
    mem_rd_en    = 1'b0;
    mem_rd_addr  = cnt_r;
    put_pos      = '0;

    unique case (state_r) inside
      ST_INIT, ST_CLEAR: begin
        mem_wr_en = 1'b1;
        if (cnt_r == LAST_CELL) begin
          cnt_nxt = '0;
          if (state_r == ST_INIT) begin
            state_nxt = ST_IDLE;
          end else begin
            res_pos_nxt  = '0;
            res_wr_nxt   = 1'b0;
            res_cell_nxt = '0;
            state_nxt    = ST_DONE;
          end
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      ST_IDLE: begin
        if (accept) begin
          ch_nxt = in_ch.character;
          unique case (in_ch.operation)
            OP_PUT: begin
              state_nxt = ST_PUT;
            end
            OP_CLEAR: begin
              cnt_nxt   = '0;
              col_nxt   = '0;
              row_nxt   = '0;
              addr_nxt  = '0;
              state_nxt = ST_CLEAR;
            end
            OP_READ: begin
              if (idx_ext < CELL_LIMIT) begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = idx_ext[ADDR_W-1:0];
                state_nxt   = ST_READ;
              end else begin
                res_pos_nxt  = '0;
                res_wr_nxt   = 1'b0;
                res_cell_nxt = '0;
                state_nxt    = ST_DONE;
              end
            end
            default: begin
              res_pos_nxt  = '0;
              res_wr_nxt   = 1'b0;
              res_cell_nxt = '0;
              state_nxt    = ST_DONE;
            end
          endcase
        end
      end

      ST_PUT: begin
        if (!is_newline) begin
          mem_wr_en   = 1'b1;
          mem_wr_addr = addr_r;
          mem_wr_data = {cfg.text_color, ch_r};
        end
        if (!wrap) begin
          col_nxt  = col_r + 1'b1;
          addr_nxt = addr_r + 1'b1;
        end else if (row_r == LAST_ROW) begin
          col_nxt  = '0;
          addr_nxt = BOTTOM_START;
        end else begin
          col_nxt  = '0;
          row_nxt  = row_r + 1'b1;
          addr_nxt = addr_r - ADDR_W'(col_r) + ROW_STEP;
        end
        put_pos = cfg.cursor_follow ? POS_W'(addr_nxt) : '0;
        if (wrap && (row_r == LAST_ROW)) begin
          res_pos_nxt  = put_pos;
          res_wr_nxt   = cfg.cursor_follow;
          res_cell_nxt = '0;
          cnt_nxt      = ROW_STEP;
          pend_nxt     = 1'b0;
          state_nxt    = ST_SCROLL;
        end else if (out_free) begin
          load_out  = 1'b1;
          ld_pos    = put_pos;
          ld_wr     = cfg.cursor_follow;
          ld_cell   = '0;
          state_nxt = ST_IDLE;
        end else begin
          res_pos_nxt  = put_pos;
          res_wr_nxt   = cfg.cursor_follow;
          res_cell_nxt = '0;
          state_nxt    = ST_DONE;
        end
      end

      ST_READ: begin
        if (out_free) begin
          load_out  = 1'b1;
          ld_pos    = '0;
          ld_wr     = 1'b0;
          ld_cell   = mem_rd_data;
          state_nxt = ST_IDLE;
        end else begin
          res_pos_nxt  = '0;
          res_wr_nxt   = 1'b0;
          res_cell_nxt = mem_rd_data;
          state_nxt    = ST_DONE;
        end
      end

      ST_SCROLL: begin
        // Read the source cell one row down while the previous read lands
        // one row up.
        mem_rd_en   = 1'b1;
        mem_rd_addr = cnt_r;
        mem_wr_en   = pend_r;
        mem_wr_addr = wdst_r;
        mem_wr_data = mem_rd_data;
        pend_nxt    = 1'b1;
        wdst_nxt    = cnt_r - ROW_STEP;
        if (cnt_r == LAST_CELL) begin
          state_nxt = ST_FLUSH;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      ST_FLUSH: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = wdst_r;
        mem_wr_data = mem_rd_data;
        pend_nxt    = 1'b0;
        cnt_nxt     = BOTTOM_START;
        state_nxt   = ST_ZERO;
      end

      ST_ZERO: begin
        mem_wr_en   = 1'b1;
        mem_wr_data = '0;
        if (cnt_r == LAST_CELL) begin
          cnt_nxt   = '0;
          state_nxt = ST_DONE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      ST_DONE: begin
        if (out_free) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_pos_r  <= ld_pos;
      out_wr_r   <= ld_wr;
      out_cell_r <= ld_cell;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.cursor_position = out_pos_r;
  assign out_ch.cursor_written  = out_wr_r;
  assign out_ch.cell_data       = out_cell_r;

  a_cursor_linear: assert property (@(posedge clk) disable iff (!rst_n)
    addr_r == ADDR_W'(int'(row_r) * COLUMNS + int'(col_r)))
    else $error("cursor address does not match row and column");

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    (int'(col_r) < COLUMNS) && (int'(row_r) < ROWS))
    else $error("cursor outside the screen");

  a_scroll_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCROLL) && mem_wr_en |-> wdst_r < cnt_r)
    else $error("scroll write overtook its source read");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ch.ready)
    else $error("second item taken while one is in work");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> out_free)
    else $error("result register reloaded before its item was taken");

endmodule

### design/text_console_writer_top.sv
// Top level of the text console writer: configuration registers, sequencer
// and screen cell memory. Depends on tcw_pkg, tcw_if.sv, tcw_cell_ram, tcw_ctrl.
// Commands arrive as items on in_ch (valid/ready): put a character, clear the
// screen or read one cell. Every command gives exactly one item on out_ch, in
// order. The cfg port writes the text color (index 0) and the cursor follow
// flag (index 1); write it only while no item is in work.
// The block takes one item at a time. A put writes its cell in the state after
// the accept, and a read fetches its cell at the accept and takes it in the
// state after, after which the result sits in the output register; an unused
// operation gives its result through the done state. A put that runs off the
// last row scrolls: the memory copies every cell up one row and zeroes the
// bottom row. A clear fills the store with blank cells, then gives its result.
// rst_n is synchronous and active low. After reset a clearing pass writes the
// blank cell into every entry while in_ch is not ready; configuration writes
// are taken as usual.
// While out_ch stalls, a finished result waits in the output register; the
// block accepts one more item and holds its result until that register is
// free, and in_ch.ready stays low meanwhile.
module text_console_writer_top
  import tcw_pkg::*;
#(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  tcw_in_if.sink                in_ch,
  tcw_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);

  // Configuration registers, cleared to a white-on-black color with cursor
  // reporting on.
  logic [COLOR_W-1:0] text_color_r;
  logic               cursor_follow_r;
  tcw_cfg_t           cfg;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_color_r    <= RESET_COLOR;
      cursor_follow_r <= RESET_FOLLOW;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TEXT_COLOR:    text_color_r    <= cfg_wdata[COLOR_W-1:0];
        REG_CURSOR_FOLLOW: cursor_follow_r <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  assign cfg.text_color    = text_color_r;
  assign cfg.cursor_follow = cursor_follow_r;

  // Memory port between the sequencer and the cell store.
  logic              mem_wr_en;
  logic [ADDR_W-1:0] mem_wr_addr;
  logic [CELL_W-1:0] mem_wr_data;
  logic              mem_rd_en;
  logic [ADDR_W-1:0] mem_rd_addr;
  logic [CELL_W-1:0] mem_rd_data;

  tcw_ctrl #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS),
    .ADDR_W  (ADDR_W)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data)
  );

  tcw_cell_ram #(
    .DEPTH  (CELL_COUNT),
    .DATA_W (CELL_W),
    .ADDR_W (ADDR_W)
  ) u_cell_ram (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

endmodule

### tb/tb_text_console_writer_top.sv
// Self-checking testbench for text_console_writer_top: drives put, clear and read items,
// keeps a shadow of the screen, cursor and registers, and compares every result item.
// Depends on tcw_pkg, tcw_if.sv and the text_console_writer_top design files.
`timescale 1ns / 1ps

module tb_text_console_writer_top
  import tcw_pkg::*;
;

  localparam int COLUMNS    = DEF_COLUMNS;
  localparam int ROWS       = DEF_ROWS;
  localparam int CELL_COUNT = COLUMNS * ROWS;

  // The operation code that the block must ignore has no name in the package.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // Length of the one long stall of the result channel, in cycles.
  localparam int LONG_HOLD_CYCLES = 300;
  // A scroll is the slowest piece of work: about one pass over the store.
  localparam int SETTLE_CYCLES = CELL_COUNT + 100;
  localparam int RANDOM_SEGMENTS = 30;
  localparam int SEGMENT_ITEMS = 50;

  // One result item, laid out as the result channel carries it.
  typedef struct packed {
    logic [POS_W-1:0]  cursor_position;
    logic              cursor_written;
    logic [CELL_W-1:0] cell_data;
  } console_result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  tcw_in_if in_ch ();
  tcw_out_if out_ch ();

  text_console_writer_top #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow copy of the console: screen store, cursor and both registers.
  logic [CELL_W-1:0]  shadow_cells [0:CELL_COUNT-1];
  int                 cur_col;
  int                 cur_row;
  logic [COLOR_W-1:0] shadow_color;
  logic               shadow_follow;

  // Results predicted for accepted items, oldest first.
  console_result_t pending_console_results [$];

  int  fail_count = 0;
  bit  idle_on = 1'b0;       // random idling on both channels
  bit  input_busy = 1'b0;    // in_ch.valid is currently being held high
  bit  hold_req = 1'b0;      // asks the result side for one long stall
  bit  hold_done = 1'b0;     // the long stall has been started
  int  hold_left = 0;
  int  stall_left = 0;

  // Fill the shadow store with white-on-black blanks and home the cursor, as the
  // block does on a clear item and during its clearing pass after reset.
  function automatic void blank_screen();
    for (int i = 0; i < CELL_COUNT; i++) shadow_cells[i] = BLANK_CELL;
    cur_col = 0;
    cur_row = 0;
  endfunction

  // Apply one accepted item to the shadow console and queue the result it gives.
  function automatic void predict_console(input logic [OP_W-1:0] op,
                                          input logic [CHAR_W-1:0] ch,
                                          input logic [IDX_W-1:0] idx);
    console_result_t res;
    res = '0;
    case (op)
      OP_PUT: begin
        // A newline jumps straight to the end of the row; anything else is
        // written at the cursor with the current color.
        if (ch != NEWLINE_CHAR) begin
          shadow_cells[cur_row * COLUMNS + cur_col] = {shadow_color, ch};
          cur_col++;
        end else begin
          cur_col = COLUMNS;
        end
        if (cur_col >= COLUMNS) begin
          cur_col = 0;
          cur_row++;
          if (cur_row >= ROWS) begin
            // Scroll up one row; the new bottom row is zero, not blank.
            cur_row = ROWS - 1;
            for (int i = 0; i + COLUMNS < CELL_COUNT; i++)
              shadow_cells[i] = shadow_cells[i + COLUMNS];
            for (int i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++)
              shadow_cells[i] = '0;
          end
        end
        if (shadow_follow) begin
          res.cursor_position = POS_W'(cur_row * COLUMNS + cur_col);
          res.cursor_written  = 1'b1;
        end
      end
      OP_CLEAR: blank_screen();
      OP_READ: begin
        // Addresses past the store read as zero.
        if (int'(idx) < CELL_COUNT) res.cell_data = shadow_cells[idx];
      end
      default: ;
    endcase
    pending_console_results.push_back(res);
  endfunction

  // Offer one item on in_ch and wait until the block takes it. valid is only
  // lowered when an idle gap is inserted, so back-to-back items keep it high
  // and no signal gets two assignments in one time step.
  task automatic offer_item(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch,
                            input logic [IDX_W-1:0] idx);
    int gap;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 11);
      if (input_busy) in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.operation  <= op;
    in_ch.character  <= ch;
    in_ch.cell_index <= idx;
    input_busy = 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_console(op, ch, idx);
  endtask

  // Drop valid and wait until every predicted result has come back, then let
  // the block settle before any register write.
  task automatic wait_drained();
    if (input_busy) begin
      in_ch.valid <= 1'b0;
      input_busy = 1'b0;
      @(posedge clk);
    end
    while (pending_console_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Single-cycle register write. The enable is lowered in the next cycle so that
  // a following write never assigns it twice in the same time step.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_TEXT_COLOR:    shadow_color = val[COLOR_W-1:0];
      REG_CURSOR_FOLLOW: shadow_follow = val[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Result side. Every accepted result item is compared against the oldest
  // prediction.
  always @(posedge clk) begin : result_monitor
    console_result_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.cursor_position, out_ch.cursor_written, out_ch.cell_data};
      if (pending_console_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("[%0t] unexpected result item: pos=%0d written=%0b cell=%h",
                   $realtime, got.cursor_position, got.cursor_written, got.cell_data);
      end else begin
        want = pending_console_results.pop_front();
        if (got.cursor_position !== want.cursor_position ||
            got.cursor_written !== want.cursor_written ||
            got.cell_data !== want.cell_data) begin
          fail_count++;
          if (fail_count <= 10)
            $display("[%0t] mismatch: exp pos=%0d wr=%0b cell=%h got pos=%0d wr=%0b cell=%h",
                     $realtime, want.cursor_position, want.cursor_written, want.cell_data,
                     got.cursor_position, got.cursor_written, got.cell_data);
        end
      end
    end
  end

  // Result side ready, redecided each cycle: one long hold, counted here, when
  // asked for; otherwise random stall bursts while idling is on.
  always @(posedge clk) begin : ready_driver
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = LONG_HOLD_CYCLES - 1;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 11) - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // The store right after the clearing pass: blank at both ends, zero past the
  // end, and the unused operation code with every field bit high.
  task automatic test_power_up_state();
    offer_item(OP_READ, 8'($urandom), '0);
    offer_item(OP_READ, 8'($urandom), IDX_W'(CELL_COUNT - 1));
    offer_item(OP_READ, 8'($urandom), IDX_W'(CELL_COUNT));
    offer_item(OP_READ, 8'($urandom), '1);
    offer_item(OP_UNUSED, 8'hFF, '1);
  endtask

  // The extreme character codes, a plain letter and a newline, then read back.
  task automatic test_put_characters();
    offer_item(OP_PUT, 8'h00, '0);
    offer_item(OP_PUT, 8'hFF, '1);
    offer_item(OP_PUT, 8'h41, '0);
    offer_item(OP_PUT, NEWLINE_CHAR, '0);
    offer_item(OP_READ, 8'($urandom), '0);
    offer_item(OP_READ, 8'($urandom), 11'd2);
    offer_item(OP_READ, 8'($urandom), IDX_W'(COLUMNS));
  endtask

  // Both registers at their extremes. The follow flag keeps only its low bit,
  // so a write of all ones but the lowest turns reporting off.
  task automatic test_registers();
    wait_drained();
    write_reg(REG_TEXT_COLOR, 8'hFF);
    write_reg(REG_CURSOR_FOLLOW, 8'hFE);
    offer_item(OP_PUT, 8'h5A, '0);
    offer_item(OP_READ, 8'($urandom), IDX_W'(cur_row * COLUMNS + cur_col - 1));
    wait_drained();
    write_reg(REG_TEXT_COLOR, 8'h00);
    write_reg(REG_CURSOR_FOLLOW, 8'h01);
    offer_item(OP_PUT, 8'h7E, '0);
    offer_item(OP_READ, 8'($urandom), IDX_W'(cur_row * COLUMNS + cur_col - 1));
  endtask

  // A clear blanks written cells and homes the cursor without reporting it.
  task automatic test_clear_screen();
    offer_item(OP_CLEAR, 8'($urandom), 11'($urandom));
    offer_item(OP_READ, 8'($urandom), '0);
    offer_item(OP_PUT, 8'h31, '0);
  endtask

  // Hold the result side off for a long stretch while items keep coming, so
  // the block fills up and stalls in_ch; then pause until everything is back.
  task automatic test_back_pressure();
    wait_drained();
    idle_on = 1'b0;
    hold_req <= 1'b1;
    for (int i = 0; i < 30; i++) begin
      if (i % 3 == 0)
        offer_item(OP_READ, 8'($urandom), IDX_W'($urandom_range(0, CELL_COUNT - 1)));
      else
        offer_item(OP_PUT, 8'($urandom), 11'($urandom));
    end
    wait_drained();
  endtask

  // Random traffic in segments. Each segment picks a newline rate so that rows
  // are ended both by newlines and by running off the right edge, and scrolls
  // happen often. Registers change between some segments; the final segments
  // run with no idling on either side.
  task automatic test_random_stream();
    int nl_pct;
    int pick;
    int base;
    logic [OP_W-1:0]   op;
    logic [CHAR_W-1:0] ch;
    logic [IDX_W-1:0]  idx;
    for (int seg = 0; seg < RANDOM_SEGMENTS; seg++) begin
      if (seg % 6 == 5) begin
        wait_drained();
        write_reg(REG_TEXT_COLOR, (seg == 5) ? 8'h00 : (seg == 11) ? 8'hFF : 8'($urandom));
        write_reg(REG_CURSOR_FOLLOW, 8'($urandom));
      end
      idle_on = (seg >= RANDOM_SEGMENTS - 3) ? 1'b0 : ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 2))
        0:       nl_pct = 0;
        1:       nl_pct = 8;
        default: nl_pct = 30;
      endcase
      for (int n = 0; n < SEGMENT_ITEMS; n++) begin
        ch   = 8'($urandom);
        idx  = 11'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 2) begin
          op = OP_CLEAR;
        end else if (pick < 5) begin
          op = OP_UNUSED;
        end else if (pick < 20) begin
          op   = OP_READ;
          pick = $urandom_range(0, 99);
          if (pick < 40) begin
            // Near the cursor, where the latest writes and scrolls land.
            base = (cur_row > 0 && pick < 15) ? (cur_row - 1) * COLUMNS : cur_row * COLUMNS;
            idx  = IDX_W'(base + $urandom_range(0, COLUMNS - 1));
          end else if (pick < 80) begin
            idx = IDX_W'($urandom_range(0, CELL_COUNT - 1));
          end else if (pick < 90) begin
            idx = IDX_W'($urandom_range(CELL_COUNT, (1 << IDX_W) - 1));
          end else begin
            case ($urandom_range(0, 3))
              0:       idx = '0;
              1:       idx = IDX_W'(CELL_COUNT - 1);
              2:       idx = IDX_W'(CELL_COUNT - COLUMNS);
              default: idx = '1;
            endcase
          end
        end else begin
          op = OP_PUT;
          if ($urandom_range(0, 99) < nl_pct) ch = NEWLINE_CHAR;
        end
        offer_item(op, ch, idx);
      end
    end
  endtask

  // Stimulus: reset once, the directed checks, the long stall, then random
  // traffic. At the end wait for every result and a scroll's worth of cycles
  // more, so that a stray extra result item is still caught.
  initial begin
    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_index        <= REG_TEXT_COLOR;
    cfg_wdata        <= '0;
    in_ch.valid      <= 1'b0;
    in_ch.operation  <= OP_PUT;
    in_ch.character  <= '0;
    in_ch.cell_index <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    blank_screen();
    shadow_color  = RESET_COLOR;
    shadow_follow = RESET_FOLLOW;

    idle_on = 1'b1;
    test_power_up_state();
    test_put_characters();
    test_registers();
    test_clear_screen();
    test_back_pressure();
    test_random_stream();

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_console_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog: several times the slowest correct run, where every item scrolls
  // and waits out the longest gaps on both sides.
  initial begin
    #40_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
